// ----- sv/srm_pkg.sv -----
// Shared types and constants for the serial register access master.
`timescale 1ns / 1ps

package srm_pkg;

  // Transaction phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_CLRHI  = 6'b000010,
    PH_HEADER = 6'b000100,
    PH_GAP    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_FINISH = 6'b100000
  } phase_e;

  // Levels driven on the link lines
  typedef struct packed {
    logic clear;
    logic strobe;
    logic data;
  } pins_t;

  // Transaction status for one tick
  typedef struct packed {
    logic busy;
    logic done;
  } status_t;

  // Top header bit on a read
  localparam logic READ_FLAG = 1'b1;

endpackage

// ----- sv/srm_if.sv -----
// Valid/ready channel interfaces for tick items and result items.
`timescale 1ns / 1ps

interface srm_req_if #(
  parameter int unsigned ADDR_BITS = 7,
  parameter int unsigned DATA_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 start_req;
  logic                 func;
  logic [ADDR_BITS-1:0] address;
  logic [DATA_BITS-1:0] write_data;
  logic                 serial_in;

  modport source (output valid, start_req, func, address, write_data, serial_in,
                  input ready);
  modport sink   (input valid, start_req, func, address, write_data, serial_in,
                  output ready);
endinterface

interface srm_res_if #(
  parameter int unsigned DATA_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 clear_line;
  logic                 strobe_line;
  logic                 serial_out;
  logic                 busy_res;
  logic                 done_res;
  logic [DATA_BITS-1:0] read_data;

  modport source (output valid, clear_line, strobe_line, serial_out, busy_res,
                  done_res, read_data, input ready);
  modport sink   (input valid, clear_line, strobe_line, serial_out, busy_res,
                  done_res, read_data, output ready);
endinterface

// ----- sv/serial_register_access_master.sv -----
// Top level of the serial register access master.
`timescale 1ns / 1ps

// Each accepted item is one tick of the serial link; it yields exactly one
// result item with the line levels, busy, done and read data of that tick.
// One item is taken per clock: the sequencer updates on acceptance and the
// result lands in an output register, so a result appears in the cycle after
// its item and the next item is taken while it waits, as long as the output
// side keeps up (ready back-pressure reaches the input in the same cycle).
// A transaction spans 2*(ADDR_BITS+1) + 2*DATA_BITS + 4 ticks from the start
// tick to the done tick; starts during a transaction are ignored.

module serial_register_access_master
  import srm_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 7,
  parameter int unsigned DATA_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srm_req_if.sink   req_i,
  srm_res_if.source res_o
);

  logic                 step;
  logic                 out_valid;
  pins_t                pins_nx, pins_out;
  status_t              status_nx, status_out;
  logic [DATA_BITS-1:0] rdata_nx, rdata_out;

  // Take an item whenever the result register is free or being drained
  assign req_i.ready = !out_valid || res_o.ready;
  assign step        = req_i.valid && req_i.ready;

  srm_seq #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .start_req_i  (req_i.start_req),
    .func_i       (req_i.func),
    .address_i    (req_i.address),
    .write_data_i (req_i.write_data),
    .serial_in_i  (req_i.serial_in),
    .pins_o       (pins_nx),
    .status_o     (status_nx),
    .read_data_o  (rdata_nx)
  );

  srm_out_stage #(
    .DATA_BITS (DATA_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .pins_i      (pins_nx),
    .status_i    (status_nx),
    .read_data_i (rdata_nx),
    .ready_i     (res_o.ready),
    .valid_o     (out_valid),
    .pins_o      (pins_out),
    .status_o    (status_out),
    .read_data_o (rdata_out)
  );

  // Drive the result channel
  assign res_o.valid       = out_valid;
  assign res_o.clear_line  = pins_out.clear;
  assign res_o.strobe_line = pins_out.strobe;
  assign res_o.serial_out  = pins_out.data;
  assign res_o.busy_res    = status_out.busy;
  assign res_o.done_res    = status_out.done;
  assign res_o.read_data   = rdata_out;

endmodule

// ----- sv/srm_seq.sv -----
// Link sequencer: phase, bit counter, shift registers and line levels.
`timescale 1ns / 1ps

module srm_seq
  import srm_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 7,
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 start_req_i,
  input  logic                 func_i,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic [DATA_BITS-1:0] write_data_i,
  input  logic                 serial_in_i,
  output pins_t                pins_o,
  output status_t              status_o,
  output logic [DATA_BITS-1:0] read_data_o
);

  localparam int unsigned HDR_W = ADDR_BITS + 1;
  localparam int unsigned MAX_IDX = (ADDR_BITS > DATA_BITS - 1) ? ADDR_BITS : DATA_BITS - 1;
  localparam int unsigned IDX_W = $clog2(MAX_IDX + 1);

  phase_e               phase_q, phase_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 sub_q, sub_d;
  logic                 rd_q, rd_d;
  logic [HDR_W-1:0]     hdr_q, hdr_d;
  logic [DATA_BITS-1:0] dat_q, dat_d;
  pins_t                pins_q, pins_d;

  // Next state and the levels of this tick
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    sub_d       = sub_q;
    rd_d        = rd_q;
    hdr_d       = hdr_q;
    dat_d       = dat_q;
    pins_d      = pins_q;
    status_o    = '{busy: 1'b1, done: 1'b0};
    read_data_o = '0;
    case (phase_q)
      PH_CLRHI: begin
        pins_d.clear = 1'b1;
        phase_d      = PH_HEADER;
        idx_d        = IDX_W'(ADDR_BITS);
        sub_d        = 1'b0;
      end
      PH_HEADER: begin
        if (!sub_q) begin
          pins_d.strobe = 1'b0;
          pins_d.data   = hdr_q[HDR_W-1];
          sub_d         = 1'b1;
        end else begin
          pins_d.strobe = 1'b1;
          sub_d         = 1'b0;
          hdr_d         = hdr_q << 1;
          if (idx_q == '0) begin
            phase_d = PH_GAP;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      PH_GAP: begin
        pins_d.strobe = 1'b0;
        phase_d       = PH_DATA;
        idx_d         = IDX_W'(DATA_BITS - 1);
        sub_d         = 1'b0;
      end
      PH_DATA: begin
        if (!sub_q) begin
          // drive the write bit on the rising strobe
          if (!rd_q) begin
            pins_d.data = dat_q[DATA_BITS-1];
          end
          pins_d.strobe = 1'b1;
          sub_d         = 1'b1;
        end else begin
          // advance the shifter; a read samples the slave line
          pins_d.strobe = 1'b0;
          dat_d         = (dat_q << 1) | DATA_BITS'(rd_q & serial_in_i);
          sub_d         = 1'b0;
          if (idx_q == '0) begin
            phase_d = PH_FINISH;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      PH_FINISH: begin
        pins_d.strobe = 1'b1;
        status_o.done = 1'b1;
        if (rd_q) begin
          read_data_o = dat_q;
        end
        phase_d = PH_IDLE;
      end
      default: begin
        // idle: latch a new transaction on a start
        phase_d = PH_IDLE;
        if (start_req_i) begin
          rd_d         = func_i;
          hdr_d        = {func_i & READ_FLAG, address_i};
          dat_d        = func_i ? '0 : write_data_i;
          idx_d        = '0;
          sub_d        = 1'b0;
          pins_d.clear = 1'b0;
          phase_d      = PH_CLRHI;
        end else begin
          status_o.busy = 1'b0;
        end
      end
    endcase
  end

  assign pins_o = pins_d;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      sub_q   <= 1'b0;
      rd_q    <= 1'b0;
      pins_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
      rd_q    <= rd_d;
      pins_q  <= pins_d;
    end
  end

  // Shift registers
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hdr_q <= hdr_d;
      dat_q <= dat_d;
    end
  end

endmodule

// ----- sv/srm_out_stage.sv -----
// Result register with valid flag for the output channel.
`timescale 1ns / 1ps

module srm_out_stage
  import srm_pkg::*;
#(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  pins_t                pins_i,
  input  status_t              status_i,
  input  logic [DATA_BITS-1:0] read_data_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output pins_t                pins_o,
  output status_t              status_o,
  output logic [DATA_BITS-1:0] read_data_o
);

  logic                 valid_q;
  pins_t                pins_q;
  status_t              status_q;
  logic [DATA_BITS-1:0] rdata_q;

  // Set on load, drop once the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pins_q   <= pins_i;
      status_q <= status_i;
      rdata_q  <= read_data_i;
    end
  end

  assign valid_o     = valid_q;
  assign pins_o      = pins_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;

endmodule
